### sv/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg
// Types, constants and fixed-point helpers shared by the SGD momentum
// update block.
// ----------------------------------------------------------------------------
package sgdm_pkg;

  // Velocity store
  localparam int VEL_DEPTH = 4096;
  localparam int SLOT_W    = $clog2(VEL_DEPTH);

  // Result queue, also the bound on items in flight
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE   = 2'd0,
    CFG_MOMENTUM_FACTOR = 2'd1,
    CFG_USE_MOMENTUM    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0]        element_index;
    logic signed [31:0] weight;
    logic signed [31:0] gradient;
    logic               end_of_pass;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        out_index;
    logic signed [31:0] new_weight;
    logic               saturated;
  } out_item_t;

  // Item leaving the velocity stages
  typedef struct packed {
    logic [11:0]        index;
    logic signed [31:0] weight;
    logic signed [31:0] velocity;
    logic               clip;
  } vel_item_t;

  // Occupancy of the first velocity stage, for the same-slot interlock
  typedef struct packed {
    logic              s1_write;
    logic [SLOT_W-1:0] s1_slot;
  } vel_status_t;

  function automatic logic [SLOT_W-1:0] slot_of(logic [11:0] idx);
    return SLOT_W'(32'(idx) % VEL_DEPTH);
  endfunction

  function automatic logic ovf32(logic signed [33:0] x);
    return (x > 34'(S32_MAX)) || (x < 34'(S32_MIN));
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'(S32_MAX)) begin
      r = S32_MAX;
    end else if (x < 34'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### sv/sgdm_velocity_unit.sv
// ----------------------------------------------------------------------------
// sgdm_velocity_unit
// Velocity store with read, decay multiply, accumulate and write back.
// ----------------------------------------------------------------------------
module sgdm_velocity_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   issue,
  input  sgdm_pkg::in_item_t     item,
  input  logic                   use_mom,
  input  logic                   first,
  input  logic [15:0]            momentum_factor,
  output logic                   vel_valid,
  output sgdm_pkg::vel_item_t    vel,
  output sgdm_pkg::vel_status_t  status
);

  logic [31:0] mem [sgdm_pkg::VEL_DEPTH];
  logic [31:0] rd_data;

  // stage 1: read data returns
  logic                        s1_valid;
  logic                        s1_write;
  logic                        s1_first;
  logic [sgdm_pkg::SLOT_W-1:0] s1_slot;
  logic [11:0]                 s1_index;
  logic signed [31:0]          s1_weight;
  logic signed [31:0]          s1_grad;

  // stage 2: decay product registered
  logic                        s2_valid;
  logic                        s2_write;
  logic                        s2_first;
  logic [sgdm_pkg::SLOT_W-1:0] s2_slot;
  logic [11:0]                 s2_index;
  logic signed [31:0]          s2_weight;
  logic signed [31:0]          s2_grad;
  logic signed [48:0]          s2_prod;

  // stage 3: new velocity registered
  logic                        s3_write;
  logic [sgdm_pkg::SLOT_W-1:0] s3_slot;

  logic                        fwd;
  logic signed [31:0]          old_vel;
  logic signed [33:0]          mom_sum;
  logic signed [31:0]          vel_next;
  logic                        clip_next;

  // The write of the item two stages ahead lands at the same edge as this
  // read; take it from the stage 3 register instead.
  assign fwd     = vel_valid && s3_write && (s3_slot == s1_slot);
  assign old_vel = fwd ? vel.velocity : $signed(rd_data);

  assign mom_sum = 34'(s2_prod >>> 16) + 34'(s2_grad);

  always_comb begin
    if (!s2_write || s2_first) begin
      vel_next  = s2_grad;
      clip_next = 1'b0;
    end else begin
      vel_next  = sgdm_pkg::sat32(mom_sum);
      clip_next = sgdm_pkg::ovf32(mom_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[sgdm_pkg::slot_of(item.element_index)];
    end
    if (s2_valid && s2_write) begin
      mem[s2_slot] <= vel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      vel_valid <= 1'b0;
    end else begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      vel_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_write  <= use_mom;
    s1_first  <= first;
    s1_slot   <= sgdm_pkg::slot_of(item.element_index);
    s1_index  <= item.element_index;
    s1_weight <= item.weight;
    s1_grad   <= item.gradient;

    s2_write  <= s1_write;
    s2_first  <= s1_first;
    s2_slot   <= s1_slot;
    s2_index  <= s1_index;
    s2_weight <= s1_weight;
    s2_grad   <= s1_grad;
    s2_prod   <= 49'(old_vel) * 49'($signed({1'b0, momentum_factor}));

    s3_write     <= s2_write;
    s3_slot      <= s2_slot;
    vel.index    <= s2_index;
    vel.weight   <= s2_weight;
    vel.velocity <= vel_next;
    vel.clip     <= clip_next;
  end

  assign status.s1_write = s1_valid && s1_write;
  assign status.s1_slot  = s1_slot;

  // The interlock keeps two writers of one slot out of adjacent stages.
  a_no_adjacent_same_slot : assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s1_write && s2_valid && s2_write && (s1_slot == s2_slot)))
    else $error("same slot in stages 1 and 2");

endmodule

### sv/sgdm_weight_unit.sv
// ----------------------------------------------------------------------------
// sgdm_weight_unit
// Scales the velocity by the learning rate and subtracts it from the weight.
// ----------------------------------------------------------------------------
module sgdm_weight_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vel_valid,
  input  sgdm_pkg::vel_item_t  vel,
  input  logic [15:0]          learning_rate,
  output logic                 res_valid,
  output sgdm_pkg::out_item_t  res
);

  logic               s4_valid;
  logic [11:0]        s4_index;
  logic signed [31:0] s4_weight;
  logic               s4_clip;
  logic signed [48:0] s4_prod;
  logic signed [33:0] diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= vel_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_index  <= vel.index;
    s4_weight <= vel.weight;
    s4_clip   <= vel.clip;
    s4_prod   <= 49'(vel.velocity) * 49'($signed({1'b0, learning_rate}));
  end

  assign diff = 34'(s4_weight) - 34'(s4_prod >>> 16);

  assign res_valid      = s4_valid;
  assign res.out_index  = s4_index;
  assign res.new_weight = sgdm_pkg::sat32(diff);
  assign res.saturated  = s4_clip || sgdm_pkg::ovf32(diff);

endmodule

### sv/sgdm_result_fifo.sv
// ----------------------------------------------------------------------------
// sgdm_result_fifo
// Small register queue that holds finished results until the sink takes them.
// ----------------------------------------------------------------------------
module sgdm_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sgdm_pkg::out_item_t  push_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sgdm_pkg::out_item_t  out_data
);

  sgdm_pkg::out_item_t          entries [sgdm_pkg::FIFO_DEPTH];
  logic [sgdm_pkg::FIFO_AW-1:0] wr_ptr;
  logic [sgdm_pkg::FIFO_AW-1:0] rd_ptr;
  logic [sgdm_pkg::CNT_W-1:0]   count;
  logic                         pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + sgdm_pkg::CNT_W'(push) - sgdm_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> (count != sgdm_pkg::CNT_W'(sgdm_pkg::FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

endmodule

### sv/sgd_momentum_update_top.sv
// ----------------------------------------------------------------------------
// sgd_momentum_update_top
// SGD weight update, plain or with momentum, one parameter element per item.
// ----------------------------------------------------------------------------
// Takes one element per cycle when the interlock and result queue allow it,
// and returns its updated weight (read of the 4096 x 32 velocity store,
// decay multiply, accumulate and write back, rate multiply, subtract into
// the result queue). The velocity store has one write and one read port;
// a momentum item whose slot matches the item accepted in the previous
// cycle waits, all other sequences run at one item per cycle. Up to eight
// items may be outstanding; the block also stops taking items when the
// result queue could not hold them all. The store needs no clearing if the
// user writes entries on a first momentum pass before reads; not enforced.
// ----------------------------------------------------------------------------
module sgd_momentum_update_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgdm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sgdm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [15:0] learning_rate;
  logic [15:0] momentum_factor;
  logic        use_momentum;
  logic        first_pass;

  logic                        accept;
  logic                        deliver;
  logic                        hazard;
  logic [sgdm_pkg::CNT_W-1:0]  credits;

  sgdm_pkg::vel_status_t vel_status;
  logic                  vel_valid;
  sgdm_pkg::vel_item_t   vel;
  logic                  res_valid;
  sgdm_pkg::out_item_t   res;

  // Hold a momentum item whose slot is still being read one stage ahead.
  assign hazard = use_momentum && vel_status.s1_write &&
                  (sgdm_pkg::slot_of(in_data.element_index) == vel_status.s1_slot);

  assign in_ready = (credits != sgdm_pkg::CNT_W'(sgdm_pkg::FIFO_DEPTH)) && !hazard;
  assign accept   = in_valid && in_ready;
  assign deliver  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= 16'd655;
      momentum_factor <= 16'd58982;
      use_momentum    <= 1'b1;
    end else if (cfg_we) begin
      case (sgdm_pkg::cfg_reg_t'(cfg_index))
        sgdm_pkg::CFG_LEARNING_RATE:   learning_rate   <= cfg_data;
        sgdm_pkg::CFG_MOMENTUM_FACTOR: momentum_factor <= cfg_data;
        sgdm_pkg::CFG_USE_MOMENTUM:    use_momentum    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pass <= 1'b1;
      credits    <= '0;
    end else begin
      if (accept && use_momentum && in_data.end_of_pass) begin
        first_pass <= 1'b0;
      end
      credits <= credits + sgdm_pkg::CNT_W'(accept) - sgdm_pkg::CNT_W'(deliver);
    end
  end

  sgdm_velocity_unit u_vel (
    .clk             (clk),
    .rst             (rst),
    .issue           (accept),
    .item            (in_data),
    .use_mom         (use_momentum),
    .first           (first_pass),
    .momentum_factor (momentum_factor),
    .vel_valid       (vel_valid),
    .vel             (vel),
    .status          (vel_status)
  );

  sgdm_weight_unit u_wgt (
    .clk           (clk),
    .rst           (rst),
    .vel_valid     (vel_valid),
    .vel           (vel),
    .learning_rate (learning_rate),
    .res_valid     (res_valid),
    .res           (res)
  );

  sgdm_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_credit_bound : assert property (@(posedge clk) disable iff (rst)
    credits <= sgdm_pkg::CNT_W'(sgdm_pkg::FIFO_DEPTH))
    else $error("outstanding item count above queue depth");

  a_result_has_credit : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (credits != '0))
    else $error("result present with no outstanding item");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sgd_momentum_update_top. Streams parameter elements
// through the valid/ready input, predicts each updated weight in Q16.16 with
// its own velocity store and first-pass flag, and compares every output
// transfer field by field. Covers plain and momentum modes, register
// extremes, saturation of velocity and weight, and random idling on both
// sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS     = 1850;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam int          SETTLE_CYCLES    = 8;
  localparam logic [1:0]  CFG_SPARE_INDEX  = 2'd3;

  // Expected-update store and weight predictor
  class update_scoreboard;
    logic [15:0]          rate;
    logic [15:0]          decay;
    bit                   momentum_on;
    bit                   first_pass;
    logic signed [31:0]   velocity [4096];
    bit                   written [4096];
    int                   written_list [$];
    sgdm_pkg::out_item_t  expected_q [$];
    int                   errors;
    int                   checked;
    int                   clipped;
    int                   momentum_items;
    int                   plain_items;

    function new();
      rate        = 16'd655;
      decay       = 16'd58982;
      momentum_on = 1'b1;
      first_pass  = 1'b1;
    endfunction

    function void configure(logic [1:0] idx, logic [15:0] val);
      case (idx)
        sgdm_pkg::CFG_LEARNING_RATE:   rate = val;
        sgdm_pkg::CFG_MOMENTUM_FACTOR: decay = val;
        sgdm_pkg::CFG_USE_MOMENTUM:    momentum_on = val[0];
        default: ;
      endcase
    endfunction

    // floor(factor * value / 2^16)
    function longint scale(longint factor, longint value);
      return (factor * value) >>> 16;
    endfunction

    function longint saturate(longint x, inout bit clip);
      if (x > longint'(sgdm_pkg::S32_MAX)) begin
        clip = 1'b1;
        return longint'(sgdm_pkg::S32_MAX);
      end
      if (x < longint'(sgdm_pkg::S32_MIN)) begin
        clip = 1'b1;
        return longint'(sgdm_pkg::S32_MIN);
      end
      return x;
    endfunction

    function void note(sgdm_pkg::in_item_t it);
      longint              g;
      longint              w;
      longint              v;
      longint              old_v;
      longint              step;
      longint              nw;
      bit                  clip;
      int                  slot;
      sgdm_pkg::out_item_t r;
      g    = it.gradient;
      w    = it.weight;
      clip = 1'b0;
      if (momentum_on) begin
        slot = it.element_index;
        if (first_pass) begin
          v = g;
        end else begin
          old_v = velocity[slot];
          v = saturate(scale(longint'(decay), old_v) + g, clip);
        end
        velocity[slot] = v[31:0];
        if (!written[slot]) begin
          written[slot] = 1'b1;
          written_list.push_back(slot);
        end
        step = v;
        if (it.end_of_pass) first_pass = 1'b0;
        momentum_items++;
      end else begin
        step = g;
        plain_items++;
      end
      nw = saturate(w - scale(longint'(rate), step), clip);
      r.out_index  = it.element_index;
      r.new_weight = nw[31:0];
      r.saturated  = clip;
      if (clip) clipped++;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check(sgdm_pkg::out_item_t got);
      sgdm_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, index %0d", got.out_index));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.out_index !== want.out_index)
        report($sformatf("out_index %0d, want %0d", got.out_index, want.out_index));
      if (got.new_weight !== want.new_weight)
        report($sformatf("index %0d new_weight %h, want %h", want.out_index,
                         got.new_weight, want.new_weight));
      if (got.saturated !== want.saturated)
        report($sformatf("index %0d saturated %b, want %b", want.out_index,
                         got.saturated, want.saturated));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sgdm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sgdm_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = 2'd0;
  logic [15:0]         cfg_data = 16'd0;

  update_scoreboard sb = new();
  bit          calm = 1'b0;
  int          cycles = 0;
  int          sent = 0;
  int          settings = 0;
  logic [11:0] last_index = 12'd0;

  sgd_momentum_update_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Output side: random backpressure, none during calm stretches
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check(out_data);
  end

  function automatic sgdm_pkg::in_item_t item_of(logic [11:0] idx, logic [31:0] w,
                                                 logic [31:0] g, bit eop);
    sgdm_pkg::in_item_t it;
    it.element_index = idx;
    it.weight        = w;
    it.gradient      = g;
    it.end_of_pass   = eop;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 6)  return sgdm_pkg::S32_MAX;
    if (sel < 12) return sgdm_pkg::S32_MIN;
    if (sel < 16) return 32'd0;
    if (sel < 20) return 32'hFFFF_FFFF;
    if (sel < 45) return $urandom;
    // roughly +/-16.0, the usual working range
    return 32'($urandom_range(0, 2097151)) - 32'd1048576;
  endfunction

  // Later momentum passes may only touch slots that already hold a velocity
  function automatic logic [11:0] pick_index();
    if (sb.momentum_on && !sb.first_pass) begin
      if ($urandom_range(0, 99) < 15 && sb.written[last_index]) return last_index;
      return 12'(sb.written_list[$urandom_range(0, sb.written_list.size() - 1)]);
    end
    if ($urandom_range(0, 99) < 15) return last_index;
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic push(input sgdm_pkg::in_item_t it);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer done at this edge
    sb.note(it);
    last_index = it.element_index;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.configure(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  function automatic logic [15:0] pick_factor();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd655;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic configure_phase(input int ph);
    logic [15:0] r;
    logic [15:0] d;
    bit          m;
    r = pick_factor();
    d = pick_factor();
    m = ($urandom_range(0, 3) != 0);
    if (ph == 0) begin
      r = 16'hFFFF;
      d = 16'hFFFF;
      m = 1'b1;
    end else if (ph == 1) begin
      r = 16'd0;
      d = 16'd0;
      m = 1'b1;
    end
    write_reg(sgdm_pkg::CFG_LEARNING_RATE, r);
    write_reg(sgdm_pkg::CFG_MOMENTUM_FACTOR, d);
    write_reg(sgdm_pkg::CFG_USE_MOMENTUM, {15'd0, m});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_INDEX, 16'($urandom));
  endtask

  task automatic run_items(input int count);
    int left;
    int pass_len;
    left = count;
    while (left > 0) begin
      pass_len = $urandom_range(4, 40);
      if (pass_len > left) pass_len = left;
      for (int k = 0; k < pass_len; k++) begin
        push(item_of(pick_index(), rand_value(), rand_value(),
                     (k == pass_len - 1) || ($urandom_range(0, 99) < 3)));
      end
      left -= pass_len;
      sent += pass_len;
    end
  endtask

  task automatic directed();
    // reset values, first momentum pass: extremes and clipped weights
    push(item_of(12'd0,    32'd0,             32'd0,             1'b0));
    push(item_of(12'd4095, sgdm_pkg::S32_MAX, sgdm_pkg::S32_MIN, 1'b0));
    push(item_of(12'd1,    sgdm_pkg::S32_MIN, sgdm_pkg::S32_MAX, 1'b0));
    push(item_of(12'd2048, 32'hFFFF_FFFF,     32'hFFFF_FFFF,     1'b0));
    push(item_of(12'hAAA,  32'h5555_5555,     32'hAAAA_AAAA,     1'b0));
    push(item_of(12'h555,  32'hAAAA_AAAA,     32'h5555_5555,     1'b0));
    drain();
    // plain mode: end of pass must leave the first-pass mark alone
    write_reg(sgdm_pkg::CFG_USE_MOMENTUM, 16'd0);
    write_reg(sgdm_pkg::CFG_LEARNING_RATE, 16'hFFFF);
    push(item_of(12'd100,  sgdm_pkg::S32_MIN, sgdm_pkg::S32_MAX, 1'b1));
    push(item_of(12'd4095, sgdm_pkg::S32_MAX, sgdm_pkg::S32_MIN, 1'b0));
    push(item_of(12'd0,    32'd0,             32'hFFFF_FFFF,     1'b1));
    drain();
    // back to momentum, still first pass; the spare index must do nothing
    write_reg(sgdm_pkg::CFG_USE_MOMENTUM, 16'd1);
    write_reg(CFG_SPARE_INDEX, 16'd0);
    push(item_of(12'd3000, 32'd5,             32'd7,             1'b0));
    push(item_of(12'd7,    32'h0001_0000,     32'h0000_8000,     1'b1));
    // second pass: velocity saturates both ways, same slot back to back
    push(item_of(12'd4095, 32'd0,             sgdm_pkg::S32_MIN, 1'b0));
    push(item_of(12'd1,    32'd0,             sgdm_pkg::S32_MAX, 1'b0));
    push(item_of(12'd1,    32'd0,             sgdm_pkg::S32_MAX, 1'b0));
    push(item_of(12'd2048, sgdm_pkg::S32_MAX, 32'd1,             1'b0));
    push(item_of(12'd7,    32'd0,             32'hFFFF_0000,     1'b1));
  endtask

  initial begin
    int phase;
    int half;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      configure_phase(phase);
      calm = (phase == 2) || (phase == 3);
      half = $urandom_range(40, 100);
      run_items(half);
      // hold off until the pipeline is empty, then resume
      if (phase == 5 || $urandom_range(0, 3) == 0) drain();
      run_items($urandom_range(40, 100));
      phase++;
    end
    calm = 1'b0;
    drain();
    $display("covered %0d momentum and %0d plain items, %0d clipped, over %0d register writes",
             sb.momentum_items, sb.plain_items, sb.clipped, settings);
    $display("%0d results checked, %0d velocity slots in use", sb.checked,
             sb.written_list.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
